/* hdl/mtc_pkg.sv */
// Shared types, constants and a helper function for the MIDI transport clock.
package mtc_pkg;

	localparam int DIVIDEND_W = 32;
	localparam int DIV_BITS_PER_CYCLE = 2;
	localparam int DIV_CYCLES = DIVIDEND_W / DIV_BITS_PER_CYCLE;

	localparam int TEMPO_W = 13;
	localparam int PERIOD_W = 24;

	localparam logic [TEMPO_W-1:0] TEMPO_MIN = 13'd320;
	localparam logic [TEMPO_W-1:0] TEMPO_MAX = 13'd4800;
	localparam logic [TEMPO_W-1:0] TEMPO_RESET = 13'd1920;

	localparam logic [31:0] TAP_LIMIT_US = 32'd2000000;
	localparam logic [DIVIDEND_W-1:0] TAP_NUM = 32'd960000000;
	localparam logic [DIVIDEND_W-1:0] PERIOD_NUM = 32'd960000000;
	localparam longint unsigned CLOCK_NUM_BASE = 64'd40000000;

	typedef enum logic [3:0] {
		OP_TICK        = 4'd0,
		OP_PLAY        = 4'd1,
		OP_STOP        = 4'd2,
		OP_CONTINUE    = 4'd3,
		OP_MIDI_CLOCK  = 4'd4,
		OP_MIDI_START  = 4'd5,
		OP_MIDI_STOP   = 4'd6,
		OP_MIDI_CONT   = 4'd7,
		OP_TAP         = 4'd8,
		OP_SET_TEMPO   = 4'd9
	} opcode_t;

	function automatic logic [TEMPO_W-1:0] clamp_tempo(input logic [31:0] t);
		logic [TEMPO_W-1:0] r;
		if (t < 32'(TEMPO_MIN)) begin
			r = TEMPO_MIN;
		end else if (t > 32'(TEMPO_MAX)) begin
			r = TEMPO_MAX;
		end else begin
			r = t[TEMPO_W-1:0];
		end
		return r;
	endfunction

endpackage

/* hdl/mtc_if.sv */
// Handshake channel interfaces for events, results and configuration writes.
interface mtc_event_if;
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	logic [31:0] timestamp_us;
	logic [15:0] tempo_value;

	modport source (output valid, output opcode, output timestamp_us, output tempo_value,
		input ready);
	modport sink (input valid, input opcode, input timestamp_us, input tempo_value,
		output ready);
endinterface

interface mtc_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] tick_count;
	logic        beat_event;
	logic [31:0] beat_number;
	logic        bar_event;
	logic [29:0] bar_number;
	logic [12:0] tempo_out;
	logic [23:0] tick_period_us;
	logic        playing;

	modport source (output valid, output tick_count, output beat_event, output beat_number,
		output bar_event, output bar_number, output tempo_out, output tick_period_us,
		output playing, input ready);
	modport sink (input valid, input tick_count, input beat_event, input beat_number,
		input bar_event, input bar_number, input tempo_out, input tick_period_us,
		input playing, output ready);
endinterface

interface mtc_cfg_if;
	logic valid;
	logic ready;
	logic clock_source;

	modport source (output valid, output clock_source, input ready);
	modport sink (input valid, input clock_source, output ready);
endinterface

/* hdl/mtc_divider.sv */
// Shared restoring divider that retires two quotient bits per cycle.
module mtc_divider #(
	parameter int DIVISOR_W = 38
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [mtc_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [DIVISOR_W-1:0]            divisor,
	output logic                            busy,
	output logic                            done,
	output logic [mtc_pkg::DIVIDEND_W-1:0]  quotient
);

	localparam int DW = mtc_pkg::DIVIDEND_W;
	localparam int CNT_W = $clog2(mtc_pkg::DIV_CYCLES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mtc_pkg::DIV_CYCLES - 1);

	// Upper part holds the partial remainder, lower part shifts the dividend out
	// and the quotient in.
	logic [DIVISOR_W+DW-1:0] rq_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [DIVISOR_W-1:0]    divisor_q;

	// A zero divisor subtracts on every step, so the quotient comes out all ones.
	function automatic logic [DIVISOR_W+DW-1:0] div_step(
		input logic [DIVISOR_W+DW-1:0] rq,
		input logic [DIVISOR_W-1:0]    dsr
	);
		logic [DIVISOR_W:0] trial;
		logic [DIVISOR_W:0] diff;
		logic [DIVISOR_W+DW-1:0] r;
		trial = rq[DIVISOR_W+DW-1:DW-1];
		diff = trial - {1'b0, dsr};
		if (trial >= {1'b0, dsr}) begin
			r = {diff[DIVISOR_W-1:0], rq[DW-2:0], 1'b1};
		end else begin
			r = {trial[DIVISOR_W-1:0], rq[DW-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [DIVISOR_W+DW-1:0] div_cycle(
		input logic [DIVISOR_W+DW-1:0] rq,
		input logic [DIVISOR_W-1:0]    dsr
	);
		logic [DIVISOR_W+DW-1:0] r;
		r = rq;
		for (int i = 0; i < mtc_pkg::DIV_BITS_PER_CYCLE; i++) begin
			r = div_step(r, dsr);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rq_q <= {{DIVISOR_W{1'b0}}, dividend};
			divisor_q <= divisor;
		end else if (busy_q) begin
			rq_q <= div_cycle(rq_q, divisor_q);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = rq_q[DW-1:0];

endmodule

/* hdl/midi_transport_clock.sv */
// Top level of the MIDI transport clock: event sequencer, state and interval ring.
//
// One event is taken at a time and answered with exactly one result. A tick, a transport
// command or an event that changes nothing goes from acceptance via ST_OUT into the result
// register once it is free; a MIDI clock pulse whose interval sum comes out zero passes
// ST_RING_UPD first. Set tempo runs ST_PERIOD_MUL, ST_PERIOD_GO and ST_DIV_PERIOD; a tap
// that changes tempo runs ST_DIV_TEMPO before them and a MIDI clock pulse ST_RING_UPD and
// ST_DIV_TEMPO. Every tempo division and the following tick period division go through
// one shared divider that retires two quotient bits per cycle. The interval ring is held
// in a small memory with one valid bit per entry, so it needs no clearing pass after
// reset. The next event is accepted while a finished result still waits in the output
// register; its own result waits behind that one and the input stalls until it leaves.
module midi_transport_clock #(
	parameter int TICKS_PER_BEAT = 96,
	parameter int CLOCK_AVERAGE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	mtc_event_if.sink   events,
	mtc_result_if.source results,
	mtc_cfg_if.sink     cfg
);

	localparam int TW = mtc_pkg::TEMPO_W;
	localparam int DW = mtc_pkg::DIVIDEND_W;
	localparam int PW = mtc_pkg::PERIOD_W;
	localparam int DEPTH = CLOCK_AVERAGE_DEPTH;
	localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TOT_W = 32 + $clog2(DEPTH);
	localparam int PROD_W = TW + $clog2(TICKS_PER_BEAT + 1);
	localparam int DIV_W = (TOT_W > PROD_W) ? TOT_W : PROD_W;
	localparam int SUB_W = $clog2(TICKS_PER_BEAT);
	localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_BEAT - 1);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(DEPTH - 1);
	localparam logic [DW-1:0] CLOCK_NUM = DW'(mtc_pkg::CLOCK_NUM_BASE * DEPTH);
	localparam logic [PW-1:0] PERIOD_RESET = PW'(64'(mtc_pkg::PERIOD_NUM)
		/ (64'(mtc_pkg::TEMPO_RESET) * TICKS_PER_BEAT));

	typedef enum logic [6:0] {
		ST_IDLE       = 7'b0000001,
		ST_RING_UPD   = 7'b0000010,
		ST_DIV_TEMPO  = 7'b0000100,
		ST_PERIOD_MUL = 7'b0001000,
		ST_PERIOD_GO  = 7'b0010000,
		ST_DIV_PERIOD = 7'b0100000,
		ST_OUT        = 7'b1000000
	} state_t;

	state_t state_q;

	logic             clock_source_q;
	logic [31:0]      tick_q;
	logic [31:0]      beat_q;
	logic [SUB_W-1:0] sub_q;
	logic             playing_q;
	logic [TW-1:0]    tempo_q;
	logic [PW-1:0]    period_q;
	logic [31:0]      prev_beat_q;
	logic [29:0]      prev_bar_q;
	logic             beat_ev_q;
	logic             bar_ev_q;
	logic [POS_W-1:0] pos_q;
	logic [TOT_W-1:0] total_q;
	logic [31:0]      last_clock_q;
	logic [31:0]      last_tap_q;
	logic             tap_seen_q;
	logic             tap_mode_q;
	logic [31:0]      interval_q;
	logic [PROD_W-1:0] prod_q;

	logic [31:0]      ring_mem [0:DEPTH-1];
	logic [DEPTH-1:0] ring_vld_q;
	logic [31:0]      ring_rd_q;
	logic             ring_rd_vld_q;

	logic             out_valid_q;
	logic [31:0]      out_tick_q;
	logic             out_beat_ev_q;
	logic [31:0]      out_beat_q;
	logic             out_bar_ev_q;
	logic [TW-1:0]    out_tempo_q;
	logic [PW-1:0]    out_period_q;
	logic             out_playing_q;

	logic             acc;
	mtc_pkg::opcode_t op;
	logic [31:0]      tick_inc;
	logic [31:0]      beat_inc;
	logic [SUB_W-1:0] sub_inc;
	logic [31:0]      clk_interval;
	logic [31:0]      tap_interval;
	logic [31:0]      ring_old;
	logic [TOT_W-1:0] total_new;
	logic [32:0]      tap_sum;
	logic             ring_we;
	logic             out_load;

	logic             div_start;
	logic [DW-1:0]    div_dividend;
	logic [DIV_W-1:0] div_divisor;
	logic             div_busy;
	logic             div_done;
	logic [DW-1:0]    div_quotient;

	assign acc = events.valid && events.ready;
	assign events.ready = (state_q == ST_IDLE);
	assign op = mtc_pkg::opcode_t'(events.opcode);
	assign cfg.ready = 1'b1;

	// Beat number is kept as a counter beside the tick counter; it restarts with the
	// tick counter when that wraps around.
	always_comb begin
		tick_inc = tick_q + 32'd1;
		if (&tick_q) begin
			beat_inc = '0;
			sub_inc = '0;
		end else if (sub_q == SUB_LAST) begin
			beat_inc = beat_q + 32'd1;
			sub_inc = '0;
		end else begin
			beat_inc = beat_q;
			sub_inc = sub_q + 1'b1;
		end
	end

	assign clk_interval = events.timestamp_us - last_clock_q;
	assign tap_interval = events.timestamp_us - last_tap_q;
	assign ring_old = ring_rd_vld_q ? ring_rd_q : 32'd0;
	assign total_new = TOT_W'(total_q - TOT_W'(ring_old) + TOT_W'(interval_q));
	assign tap_sum = {1'b0, div_quotient} + 33'(tempo_q);
	assign ring_we = (state_q == ST_RING_UPD);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || results.ready);

	always_comb begin
		div_start = 1'b0;
		div_dividend = mtc_pkg::PERIOD_NUM;
		div_divisor = DIV_W'(prod_q);
		unique case (state_q)
			ST_IDLE: begin
				if (acc && op == mtc_pkg::OP_TAP && tap_seen_q
					&& tap_interval < mtc_pkg::TAP_LIMIT_US) begin
					div_start = 1'b1;
					div_dividend = mtc_pkg::TAP_NUM;
					div_divisor = DIV_W'(tap_interval);
				end
			end
			ST_RING_UPD: begin
				div_start = (total_new != '0);
				div_dividend = CLOCK_NUM;
				div_divisor = DIV_W'(total_new);
			end
			ST_PERIOD_GO: begin
				div_start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	mtc_divider #(
		.DIVISOR_W (DIV_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clock_source_q <= 1'b0;
			tick_q <= '0;
			beat_q <= '0;
			sub_q <= '0;
			playing_q <= 1'b0;
			tempo_q <= mtc_pkg::TEMPO_RESET;
			period_q <= PERIOD_RESET;
			prev_beat_q <= '0;
			prev_bar_q <= '0;
			beat_ev_q <= 1'b0;
			bar_ev_q <= 1'b0;
			pos_q <= '0;
			total_q <= '0;
			last_clock_q <= '0;
			last_tap_q <= '0;
			tap_seen_q <= 1'b0;
			tap_mode_q <= 1'b0;
			ring_vld_q <= '0;
			ring_rd_vld_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				clock_source_q <= cfg.clock_source;
			end
			ring_rd_vld_q <= ring_vld_q[pos_q];
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						beat_ev_q <= 1'b0;
						bar_ev_q <= 1'b0;
						state_q <= ST_OUT;
						unique case (op)
							mtc_pkg::OP_TICK: begin
								if (playing_q && !clock_source_q) begin
									tick_q <= tick_inc;
									beat_q <= beat_inc;
									sub_q <= sub_inc;
									if (beat_inc != prev_beat_q) begin
										prev_beat_q <= beat_inc;
										beat_ev_q <= 1'b1;
									end
									if (beat_inc[31:2] != prev_bar_q) begin
										prev_bar_q <= beat_inc[31:2];
										bar_ev_q <= 1'b1;
									end
								end
							end
							mtc_pkg::OP_PLAY: begin
								if (!playing_q) begin
									tick_q <= '0;
									beat_q <= '0;
									sub_q <= '0;
									playing_q <= 1'b1;
								end
							end
							mtc_pkg::OP_STOP, mtc_pkg::OP_MIDI_STOP: begin
								tick_q <= '0;
								beat_q <= '0;
								sub_q <= '0;
								playing_q <= 1'b0;
							end
							mtc_pkg::OP_CONTINUE, mtc_pkg::OP_MIDI_CONT: begin
								playing_q <= 1'b1;
							end
							mtc_pkg::OP_MIDI_START: begin
								tick_q <= '0;
								beat_q <= '0;
								sub_q <= '0;
								playing_q <= 1'b1;
							end
							mtc_pkg::OP_MIDI_CLOCK: begin
								// The ring entry at pos_q is read on this edge and used
								// in the next cycle.
								if (clock_source_q) begin
									interval_q <= clk_interval;
									last_clock_q <= events.timestamp_us;
									state_q <= ST_RING_UPD;
								end
							end
							mtc_pkg::OP_TAP: begin
								last_tap_q <= events.timestamp_us;
								tap_seen_q <= 1'b1;
								if (tap_seen_q && tap_interval < mtc_pkg::TAP_LIMIT_US) begin
									tap_mode_q <= 1'b1;
									state_q <= ST_DIV_TEMPO;
								end
							end
							mtc_pkg::OP_SET_TEMPO: begin
								tempo_q <= mtc_pkg::clamp_tempo(32'(events.tempo_value));
								state_q <= ST_PERIOD_MUL;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RING_UPD: begin
					total_q <= total_new;
					ring_vld_q[pos_q] <= 1'b1;
					pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
					tap_mode_q <= 1'b0;
					state_q <= (total_new != '0) ? ST_DIV_TEMPO : ST_OUT;
				end
				ST_DIV_TEMPO: begin
					if (div_done) begin
						// A tap with a zero interval divides by zero; the all-ones
						// quotient clamps to the top tempo, as intended.
						if (tap_mode_q) begin
							tempo_q <= mtc_pkg::clamp_tempo(tap_sum[32:1]);
						end else begin
							tempo_q <= mtc_pkg::clamp_tempo(div_quotient);
						end
						state_q <= ST_PERIOD_MUL;
					end
				end
				ST_PERIOD_MUL: begin
					state_q <= ST_PERIOD_GO;
				end
				ST_PERIOD_GO: begin
					state_q <= ST_DIV_PERIOD;
				end
				ST_DIV_PERIOD: begin
					if (div_done) begin
						period_q <= div_quotient[PW-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PERIOD_MUL) begin
			prod_q <= PROD_W'(tempo_q) * PROD_W'(TICKS_PER_BEAT);
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[pos_q] <= interval_q;
		end
		ring_rd_q <= ring_mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_tick_q <= tick_q;
			out_beat_ev_q <= beat_ev_q;
			out_beat_q <= beat_q;
			out_bar_ev_q <= bar_ev_q;
			out_tempo_q <= tempo_q;
			out_period_q <= period_q;
			out_playing_q <= playing_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.tick_count = out_tick_q;
	assign results.beat_event = out_beat_ev_q;
	assign results.beat_number = out_beat_q;
	assign results.bar_event = out_bar_ev_q;
	assign results.bar_number = out_beat_q[31:2];
	assign results.tempo_out = out_tempo_q;
	assign results.tick_period_us = out_period_q;
	assign results.playing = out_playing_q;

`ifndef ASSERT_OFF
	a_tempo_range: assert property (@(posedge clk) disable iff (!arst_n)
		tempo_q >= mtc_pkg::TEMPO_MIN && tempo_q <= mtc_pkg::TEMPO_MAX)
		else $error("tempo left its legal range");

	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q != ST_IDLE)
		else $error("accepted request did not leave idle");

	a_sub_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q <= SUB_LAST)
		else $error("sub-beat counter out of range");
`endif

endmodule

/* sim/mtc_checker.sv */
// Scoreboard for the MIDI transport clock: mirrors the block's state and checks every result.
module mtc_checker #(
	parameter int TICKS_PER_BEAT = 96,
	parameter int CLOCK_AVERAGE_DEPTH = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	mtc_event_if  events,
	mtc_result_if results,
	mtc_cfg_if    cfg,
	output int    errors,
	output int    pending
);

	localparam logic [12:0] BPM16_MIN = 13'd320;
	localparam logic [12:0] BPM16_MAX = 13'd4800;
	localparam logic [12:0] BPM16_RESET = 13'd1920;
	localparam logic [31:0] TAP_WINDOW_US = 32'd2000000;
	localparam longint unsigned TAP_SCALE = 64'd960000000;
	localparam longint unsigned PERIOD_SCALE = 64'd960000000;
	localparam longint unsigned PULSE_SCALE = 64'd40000000 * CLOCK_AVERAGE_DEPTH;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [31:0] tick_count;
		logic        beat_event;
		logic [31:0] beat_number;
		logic        bar_event;
		logic [29:0] bar_number;
		logic [12:0] tempo_out;
		logic [23:0] tick_period_us;
		logic        playing;
	} transport_status_t;

	transport_status_t status_q[$];
	transport_status_t want;
	transport_status_t got;

	logic              external_clock;
	logic [31:0]       tick_total;
	logic              running;
	logic [12:0]       bpm16;
	logic [31:0]       seen_beat;
	logic [29:0]       seen_bar;
	logic [31:0]       pulse_gap [CLOCK_AVERAGE_DEPTH];
	int unsigned       gap_slot;
	logic [34:0]       gap_sum;
	logic [31:0]       last_pulse_us;
	logic [31:0]       last_tap_us;
	logic              tap_armed;
	logic [31:0]       gap;
	logic [31:0]       beat;
	logic [29:0]       bar;
	logic              beat_flag;
	logic              bar_flag;
	longint unsigned   tapped;

	function automatic logic [12:0] limit_bpm16(input longint unsigned t);
		if (t < BPM16_MIN) return BPM16_MIN;
		if (t > BPM16_MAX) return BPM16_MAX;
		return 13'(t);
	endfunction

	function automatic string describe(input transport_status_t s);
		return $sformatf({"tick=%0d beat_ev=%0b beat=%0d bar_ev=%0b bar=%0d",
			" tempo=%0d period=%0d play=%0b"},
			s.tick_count, s.beat_event, s.beat_number, s.bar_event, s.bar_number,
			s.tempo_out, s.tick_period_us, s.playing);
	endfunction

	task automatic note_mismatch(input string what, input transport_status_t exp_s,
		input transport_status_t act_s);
		errors++;
		if (errors <= REPORT_LIMIT) begin
			$display("%0t: %s", $realtime, what);
			$display("  expected %s", describe(exp_s));
			$display("  actual   %s", describe(act_s));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			external_clock = 1'b0;
			tick_total = '0;
			running = 1'b0;
			bpm16 = BPM16_RESET;
			seen_beat = '0;
			seen_bar = '0;
			foreach (pulse_gap[i]) pulse_gap[i] = '0;
			gap_slot = 0;
			gap_sum = '0;
			last_pulse_us = '0;
			last_tap_us = '0;
			tap_armed = 1'b0;
			status_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				external_clock = cfg.clock_source;
			end

			// A result leaving at this edge always belongs to an earlier request.
			if (results.valid && results.ready) begin
				got.tick_count = results.tick_count;
				got.beat_event = results.beat_event;
				got.beat_number = results.beat_number;
				got.bar_event = results.bar_event;
				got.bar_number = results.bar_number;
				got.tempo_out = results.tempo_out;
				got.tick_period_us = results.tick_period_us;
				got.playing = results.playing;
				if (status_q.size() == 0) begin
					note_mismatch("result with no request outstanding", '0, got);
				end else begin
					want = status_q.pop_front();
					if (got.tick_count !== want.tick_count || got.beat_event !== want.beat_event ||
						got.beat_number !== want.beat_number || got.bar_event !== want.bar_event ||
						got.bar_number !== want.bar_number || got.tempo_out !== want.tempo_out ||
						got.tick_period_us !== want.tick_period_us ||
						got.playing !== want.playing) begin
						note_mismatch("result differs from prediction", want, got);
					end
				end
			end

			if (events.valid && events.ready) begin
				beat_flag = 1'b0;
				bar_flag = 1'b0;
				case (events.opcode)
					mtc_pkg::OP_TICK: begin
						if (running && !external_clock) begin
							tick_total = tick_total + 32'd1;
							beat = tick_total / 32'(TICKS_PER_BEAT);
							bar = 30'(beat >> 2);
							if (beat != seen_beat) begin
								seen_beat = beat;
								beat_flag = 1'b1;
							end
							if (bar != seen_bar) begin
								seen_bar = bar;
								bar_flag = 1'b1;
							end
						end
					end
					mtc_pkg::OP_PLAY: begin
						if (!running) begin
							tick_total = '0;
							running = 1'b1;
						end
					end
					mtc_pkg::OP_STOP, mtc_pkg::OP_MIDI_STOP: begin
						running = 1'b0;
						tick_total = '0;
					end
					mtc_pkg::OP_CONTINUE, mtc_pkg::OP_MIDI_CONT: begin
						running = 1'b1;
					end
					mtc_pkg::OP_MIDI_START: begin
						tick_total = '0;
						running = 1'b1;
					end
					mtc_pkg::OP_MIDI_CLOCK: begin
						// The ring keeps a running sum so the average is one divide.
						if (external_clock) begin
							gap = events.timestamp_us - last_pulse_us;
							last_pulse_us = events.timestamp_us;
							gap_sum = gap_sum - 35'(pulse_gap[gap_slot]) + 35'(gap);
							pulse_gap[gap_slot] = gap;
							gap_slot = (gap_slot + 1) % CLOCK_AVERAGE_DEPTH;
							if (gap_sum != '0) begin
								bpm16 = limit_bpm16(PULSE_SCALE / 64'(gap_sum));
							end
						end
					end
					mtc_pkg::OP_TAP: begin
						// Taps too far apart restart counting and leave the tempo alone.
						if (tap_armed) begin
							gap = events.timestamp_us - last_tap_us;
							if (gap < TAP_WINDOW_US) begin
								tapped = (gap == '0) ? 64'(BPM16_MAX) * 2 : TAP_SCALE / 64'(gap);
								bpm16 = limit_bpm16((64'(bpm16) + tapped) / 2);
							end
						end
						last_tap_us = events.timestamp_us;
						tap_armed = 1'b1;
					end
					mtc_pkg::OP_SET_TEMPO: begin
						bpm16 = limit_bpm16(64'(events.tempo_value));
					end
					default: ;
				endcase
				want.tick_count = tick_total;
				want.beat_event = beat_flag;
				want.beat_number = tick_total / 32'(TICKS_PER_BEAT);
				want.bar_event = bar_flag;
				want.bar_number = 30'(want.beat_number >> 2);
				want.tempo_out = bpm16;
				want.tick_period_us = 24'(PERIOD_SCALE / (64'(bpm16) * 64'(TICKS_PER_BEAT)));
				want.playing = running;
				status_q.push_back(want);
			end
			pending = status_q.size();
		end
	end

endmodule

/* sim/tb.sv */
// Testbench top for the MIDI transport clock: stimulus, flow control and the verdict.
module tb;

	localparam int HALF_PERIOD = 10;
	localparam int ITEM_TARGET = 1800;
	localparam int PHASE_ITEMS = 300;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 20000;
	localparam int SETTLE_CYCLES = 45;
	localparam int IDLE_PERCENT = 19;
	localparam logic [3:0] OP_SPARE_FIRST = 4'd10;
	localparam logic [3:0] OP_SPARE_LAST = 4'd15;
	localparam logic [15:0] BPM16_LOW = 16'd320;
	localparam logic [15:0] BPM16_HIGH = 16'd4800;
	localparam logic [31:0] TAP_WINDOW_US = 32'd2000000;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          quiet;
	bit          ext_src;
	bit          transport_on;
	int          counted;
	int          holds_asked;
	int          holds_done;
	int          err_count;
	int          open_count;
	logic [31:0] pulse_us;
	logic [31:0] tap_us;

	mtc_event_if  ev_if ();
	mtc_result_if res_if ();
	mtc_cfg_if    cfg_if ();

	midi_transport_clock u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (ev_if),
		.results (res_if),
		.cfg     (cfg_if)
	);

	mtc_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (ev_if),
		.results (res_if),
		.cfg     (cfg_if),
		.errors  (err_count),
		.pending (open_count)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic send_event(input logic [3:0] op, input logic [31:0] ts, input logic [15:0] tv);
		while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
			ev_if.valid <= 1'b0;
			@(posedge clk);
		end
		ev_if.valid <= 1'b1;
		ev_if.opcode <= op;
		ev_if.timestamp_us <= ts;
		ev_if.tempo_value <= tv;
		@(posedge clk);
		while (!ev_if.ready) @(posedge clk);
		counted++;
		case (op)
			mtc_pkg::OP_PLAY, mtc_pkg::OP_CONTINUE, mtc_pkg::OP_MIDI_CONT,
			mtc_pkg::OP_MIDI_START: transport_on = 1'b1;
			mtc_pkg::OP_STOP, mtc_pkg::OP_MIDI_STOP: transport_on = 1'b0;
			default: ;
		endcase
	endtask

	// Waits, up to a limit, until every request has its result, then lets the block settle.
	task automatic drain();
		int n;
		n = 0;
		ev_if.valid <= 1'b0;
		do begin
			@(negedge clk);
			n++;
		end while (open_count != 0 && n < DRAIN_CYCLES);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_source(input bit v);
		drain();
		cfg_if.valid <= 1'b1;
		cfg_if.clock_source <= v;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		ext_src = v;
	endtask

	function automatic logic [15:0] pick_tempo();
		int r;
		r = $urandom_range(99);
		if (r < 50) return 16'($urandom_range(65535));
		if (r < 85) return 16'($urandom_range(BPM16_HIGH, BPM16_LOW));
		case ($urandom_range(3))
			0: return BPM16_LOW - 16'd1;
			1: return BPM16_LOW;
			2: return BPM16_HIGH;
			default: return BPM16_HIGH + 16'd1;
		endcase
	endfunction

	// Mostly a steady pulse train, with bursts, stalls and jumps mixed in.
	function automatic logic [31:0] next_pulse_time();
		int r;
		r = $urandom_range(99);
		if (r < 85) pulse_us += $urandom_range(60000, 5000);
		else if (r < 92) pulse_us += $urandom_range(200);
		else if (r < 97) pulse_us += $urandom;
		else pulse_us = $urandom;
		return pulse_us;
	endfunction

	function automatic logic [31:0] next_tap_time();
		int r;
		r = $urandom_range(99);
		if (r < 80) tap_us += $urandom_range(TAP_WINDOW_US - 1, 150000);
		else if (r < 86) tap_us += $urandom_range(3);
		else if (r < 94) tap_us += $urandom_range(3 * TAP_WINDOW_US, TAP_WINDOW_US);
		else if (r < 97) tap_us += TAP_WINDOW_US - 1 + $urandom_range(1);
		else tap_us = $urandom;
		return tap_us;
	endfunction

	task automatic send_random();
		logic [3:0] op;
		logic [31:0] ts;
		int r;
		r = $urandom_range(99);
		if (r < 50) op = ext_src ? mtc_pkg::OP_MIDI_CLOCK : mtc_pkg::OP_TICK;
		else if (r < 62) op = mtc_pkg::OP_TAP;
		else if (r < 68) op = mtc_pkg::OP_SET_TEMPO;
		else if (r < 72) op = ext_src ? mtc_pkg::OP_TICK : mtc_pkg::OP_MIDI_CLOCK;
		else if (r < 76) op = mtc_pkg::OP_PLAY;
		else if (r < 79) op = mtc_pkg::OP_CONTINUE;
		else if (r < 82) op = mtc_pkg::OP_MIDI_CONT;
		else if (r < 85) op = mtc_pkg::OP_MIDI_START;
		else if (r < 87) op = mtc_pkg::OP_STOP;
		else if (r < 89) op = mtc_pkg::OP_MIDI_STOP;
		else if (r < 92) op = 4'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
		else op = ext_src ? mtc_pkg::OP_MIDI_CLOCK : mtc_pkg::OP_TICK;
		ts = $urandom;
		if (op == mtc_pkg::OP_MIDI_CLOCK) ts = next_pulse_time();
		else if (op == mtc_pkg::OP_TAP) ts = next_tap_time();
		send_event(op, ts, pick_tempo());
	endtask

	task automatic run_phase();
		int start;
		int hold_at;
		bit held;
		start = counted;
		hold_at = $urandom_range(PHASE_ITEMS - 1);
		held = 1'b0;
		while (counted - start < PHASE_ITEMS) begin
			if (!held && counted - start >= hold_at) begin
				holds_asked++;
				held = 1'b1;
			end
			// Long tick runs carry the count across beat and bar boundaries.
			if (!ext_src && $urandom_range(99) < 3) begin
				if (!transport_on) send_event(mtc_pkg::OP_PLAY, $urandom, pick_tempo());
				repeat ($urandom_range(400, 60)) begin
					send_event(mtc_pkg::OP_TICK, $urandom, pick_tempo());
				end
			end else begin
				send_random();
			end
		end
	endtask

	// Result side: random back-pressure, plus long hold-offs on request.
	initial begin
		res_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				holds_done = holds_asked;
				res_if.ready <= 1'b0;
				repeat ($urandom_range(400, 200)) @(posedge clk);
			end
			res_if.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	initial begin
		#(LIMIT_CYCLES * 2 * HALF_PERIOD);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int phase;
		arst_n <= 1'b0;
		ev_if.valid <= 1'b0;
		ev_if.opcode <= mtc_pkg::OP_TICK;
		ev_if.timestamp_us <= '0;
		ev_if.tempo_value <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.clock_source <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Transport commands, a MIDI clock pulse and set tempo with the internal source.
		send_event(mtc_pkg::OP_TICK, 32'd0, 16'd0);
		send_event(mtc_pkg::OP_PLAY, 32'd10, 16'd0);
		send_event(mtc_pkg::OP_TICK, 32'd20, 16'd0);
		send_event(mtc_pkg::OP_PLAY, 32'd30, 16'd0);
		send_event(mtc_pkg::OP_TICK, 32'd40, 16'd0);
		send_event(mtc_pkg::OP_STOP, 32'd50, 16'd0);
		send_event(mtc_pkg::OP_CONTINUE, 32'd60, 16'd0);
		send_event(mtc_pkg::OP_TICK, 32'd70, 16'd0);
		send_event(mtc_pkg::OP_MIDI_STOP, 32'd80, 16'd0);
		send_event(mtc_pkg::OP_MIDI_CONT, 32'd90, 16'd0);
		send_event(mtc_pkg::OP_MIDI_START, 32'd100, 16'd0);
		send_event(mtc_pkg::OP_MIDI_CLOCK, 32'hFFFF_FFFF, 16'hFFFF);
		send_event(mtc_pkg::OP_SET_TEMPO, 32'd0, 16'd0);
		send_event(mtc_pkg::OP_SET_TEMPO, 32'd0, 16'hFFFF);
		// Tap tempo: first tap, zero interval, normal, exactly at the window, wrap.
		send_event(mtc_pkg::OP_TAP, 32'd1000, 16'd0);
		send_event(mtc_pkg::OP_TAP, 32'd1000, 16'd0);
		send_event(mtc_pkg::OP_TAP, 32'd501000, 16'd0);
		send_event(mtc_pkg::OP_TAP, 32'd501000 + TAP_WINDOW_US, 16'd0);
		send_event(mtc_pkg::OP_TAP, 32'hFFFF_FF00, 16'd0);
		send_event(mtc_pkg::OP_TAP, 32'h0000_0100, 16'd0);
		send_event(OP_SPARE_LAST, 32'h5555_AAAA, 16'hAAAA);

		// External clock: first pulse measures from time zero.
		set_source(1'b1);
		send_event(mtc_pkg::OP_MIDI_CLOCK, 32'd0, 16'd0);
		send_event(mtc_pkg::OP_MIDI_CLOCK, 32'd20833, 16'd0);
		send_event(mtc_pkg::OP_TICK, 32'd20900, 16'd0);
		send_event(mtc_pkg::OP_MIDI_CLOCK, 32'hFFFF_FFFF, 16'd0);
		pulse_us = 32'hFFFF_FFFF;
		tap_us = 32'h0000_0100;

		counted = 0;
		for (phase = 0; counted < ITEM_TARGET; phase++) begin
			set_source(phase[0]);
			quiet = (phase == 2);
			run_phase();
		end
		quiet = 1'b0;
		drain();

		if (err_count == 0 && open_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
